// ----- rtl/core/dac_pkg.sv -----
package dac_pkg;

	localparam int PADDR_W   = 5;
	localparam int DIV_STEPS = 17;
	localparam int CNT_W     = 5;

	localparam logic [7:0] LETTER_BASE = 8'd65;

	typedef enum logic [2:0] {
		REG_DIRECTION  = 3'd0,
		REG_MODULUS    = 3'd1,
		REG_INNER_MULT = 3'd2,
		REG_INNER_ADD  = 3'd3,
		REG_OUTER_MULT = 3'd4,
		REG_OUTER_ADD  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic       direction;
		logic [7:0] modulus;
		logic [7:0] inner_mult;
		logic [7:0] inner_add;
		logic [7:0] outer_mult;
		logic [7:0] outer_add;
	} cfg_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_EU_INIT_A,
		CMD_EU_INIT_C,
		CMD_EU_STEP,
		CMD_SAVE_A,
		CMD_SAVE_C,
		CMD_MOD0,
		CMD_MOD1,
		CMD_MOD2,
		CMD_WRITE_OK,
		CMD_WRITE_BAD
	} cmd_t;

	typedef enum logic [1:0] {
		DST_ACC,
		DST_EU_INIT,
		DST_EU_STEP
	} dest_t;

	typedef struct packed {
		logic busy;
		logic r1_zero;
		logic key_zero;
		logic inv_valid;
		logic inv_ok;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/core/dac_item_if.sv -----
interface dac_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       start_of_message;

	modport source (output valid, output symbol, output start_of_message, input ready);
	modport sink (input valid, input symbol, input start_of_message, output ready);
endinterface

// ----- rtl/core/dac_result_if.sv -----
interface dac_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_symbol;
	logic       key_invalid;

	modport source (output valid, output out_symbol, output key_invalid, input ready);
	modport sink (input valid, input out_symbol, input key_invalid, output ready);
endinterface

// ----- rtl/core/chained_double_affine_cipher_unit.sv -----
// channel  | role   | payload
// item     | sink   | symbol[7:0], start_of_message
// result   | source | out_symbol[7:0], key_invalid
// apb      | slave  | six key registers at byte offsets 0x00..0x14
//
// One word at a time: three reductions through the shared 17-step restoring
// divider, plus load, check and write.
// After any register write the first word whose key fields are all nonzero also
// runs extended Euclid for both inverses on the same divider.
// arst_n clears the key to its defaults, the chaining value and the inverse cache.
// A finished word waits in the output register while the next word is taken.
module chained_double_affine_cipher_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	dac_item_if.sink                    item,
	dac_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dac_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	dac_pkg::cfg_t  cfg;
	logic           cfg_wr;
	dac_pkg::cmd_t  cmd;
	dac_pkg::stat_t stat;

	dac_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.cfg_wr (cfg_wr)
	);

	dac_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_ready(item.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dac_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cfg_wr          (cfg_wr),
		.cmd             (cmd),
		.stat            (stat),
		.symbol          (item.symbol),
		.start_of_message(item.start_of_message),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.out_symbol      (result.out_symbol),
		.key_invalid     (result.key_invalid)
	);
endmodule

// ----- rtl/core/dac_regs.sv -----
module dac_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dac_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output dac_pkg::cfg_t               cfg,
	output logic                        cfg_wr
);
	dac_pkg::cfg_t     cfg_q;
	dac_pkg::reg_idx_t idx;
	logic              wr;

	assign idx    = dac_pkg::reg_idx_t'(paddr[dac_pkg::PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign cfg_wr = wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction  <= 1'b0;
			cfg_q.modulus    <= 8'd26;
			cfg_q.inner_mult <= 8'd1;
			cfg_q.inner_add  <= 8'd1;
			cfg_q.outer_mult <= 8'd1;
			cfg_q.outer_add  <= 8'd1;
		end else if (wr) begin
			case (idx)
				dac_pkg::REG_DIRECTION:  cfg_q.direction  <= pwdata[0];
				dac_pkg::REG_MODULUS:    cfg_q.modulus    <= pwdata[7:0];
				dac_pkg::REG_INNER_MULT: cfg_q.inner_mult <= pwdata[7:0];
				dac_pkg::REG_INNER_ADD:  cfg_q.inner_add  <= pwdata[7:0];
				dac_pkg::REG_OUTER_MULT: cfg_q.outer_mult <= pwdata[7:0];
				dac_pkg::REG_OUTER_ADD:  cfg_q.outer_add  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dac_pkg::REG_DIRECTION:  prdata = {31'd0, cfg_q.direction};
			dac_pkg::REG_MODULUS:    prdata = {24'd0, cfg_q.modulus};
			dac_pkg::REG_INNER_MULT: prdata = {24'd0, cfg_q.inner_mult};
			dac_pkg::REG_INNER_ADD:  prdata = {24'd0, cfg_q.inner_add};
			dac_pkg::REG_OUTER_MULT: prdata = {24'd0, cfg_q.outer_mult};
			dac_pkg::REG_OUTER_ADD:  prdata = {24'd0, cfg_q.outer_add};
			default:                 prdata = 32'd0;
		endcase
	end
endmodule

// ----- rtl/core/dac_ctrl.sv -----
module dac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dac_pkg::stat_t stat,
	output dac_pkg::cmd_t  cmd
);
	typedef enum logic [15:0] {
		ST_IDLE   = 16'h0001,
		ST_CHECK  = 16'h0002,
		ST_INV_A  = 16'h0004,
		ST_WAIT_A = 16'h0008,
		ST_SAVE_A = 16'h0010,
		ST_INV_C  = 16'h0020,
		ST_WAIT_C = 16'h0040,
		ST_SAVE_C = 16'h0080,
		ST_RUN0   = 16'h0100,
		ST_W0     = 16'h0200,
		ST_RUN1   = 16'h0400,
		ST_W1     = 16'h0800,
		ST_RUN2   = 16'h1000,
		ST_W2     = 16'h2000,
		ST_FINISH = 16'h4000,
		ST_BAD    = 16'h8000
	} state_t;

	state_t state_q, state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = dac_pkg::CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd       = dac_pkg::CMD_LOAD;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.key_zero || (stat.inv_valid && !stat.inv_ok))
					state_nxt = ST_BAD;
				else if (stat.inv_valid)
					state_nxt = ST_RUN0;
				else
					state_nxt = ST_INV_A;
			end
			ST_INV_A: begin
				cmd       = dac_pkg::CMD_EU_INIT_A;
				state_nxt = ST_WAIT_A;
			end
			ST_WAIT_A: begin
				if (!stat.busy) begin
					if (stat.r1_zero)
						state_nxt = ST_SAVE_A;
					else
						cmd = dac_pkg::CMD_EU_STEP;
				end
			end
			ST_SAVE_A: begin
				cmd       = dac_pkg::CMD_SAVE_A;
				state_nxt = ST_INV_C;
			end
			ST_INV_C: begin
				cmd       = dac_pkg::CMD_EU_INIT_C;
				state_nxt = ST_WAIT_C;
			end
			ST_WAIT_C: begin
				if (!stat.busy) begin
					if (stat.r1_zero)
						state_nxt = ST_SAVE_C;
					else
						cmd = dac_pkg::CMD_EU_STEP;
				end
			end
			ST_SAVE_C: begin
				cmd       = dac_pkg::CMD_SAVE_C;
				state_nxt = ST_CHECK;
			end
			ST_RUN0: begin
				cmd       = dac_pkg::CMD_MOD0;
				state_nxt = ST_W0;
			end
			ST_W0: begin
				if (!stat.busy)
					state_nxt = ST_RUN1;
			end
			ST_RUN1: begin
				cmd       = dac_pkg::CMD_MOD1;
				state_nxt = ST_W1;
			end
			ST_W1: begin
				if (!stat.busy)
					state_nxt = ST_RUN2;
			end
			ST_RUN2: begin
				cmd       = dac_pkg::CMD_MOD2;
				state_nxt = ST_W2;
			end
			ST_W2: begin
				if (!stat.busy)
					state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd       = dac_pkg::CMD_WRITE_OK;
					state_nxt = ST_IDLE;
				end
			end
			ST_BAD: begin
				if (stat.out_free) begin
					cmd       = dac_pkg::CMD_WRITE_BAD;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end
endmodule

// ----- rtl/core/dac_dp.sv -----
module dac_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  dac_pkg::cfg_t  cfg,
	input  logic           cfg_wr,
	input  dac_pkg::cmd_t  cmd,
	output dac_pkg::stat_t stat,
	input  logic [7:0]     symbol,
	input  logic           start_of_message,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_symbol,
	output logic           key_invalid
);
	logic [7:0]                sym_q;
	logic signed [9:0]         chain_q;
	logic [7:0]                acc_q;
	logic [7:0]                inva_q, invc_q;
	logic                      inv_valid_q;
	logic [7:0]                r0_q, r1_q;
	logic signed [9:0]         t0_q, t1_q;
	logic [16:0]               mag_q;
	logic [7:0]                rem_q, div_q;
	logic                      neg_q, busy_q;
	logic [dac_pkg::CNT_W-1:0] cnt_q;
	dac_pkg::dest_t            dest_q;
	logic                      out_valid_q, key_invalid_q;
	logic [7:0]                out_symbol_q;

	logic signed [9:0]  x_s;
	logic [7:0]         mul_op;
	logic [15:0]        prod;
	logic signed [17:0] prod_s, v;
	logic [16:0]        mag;
	logic [7:0]         divisor;
	logic               start_div;
	dac_pkg::dest_t     dest;
	logic [8:0]         trial;
	logic               ge;
	logic [7:0]         rem_fix, inv_res;
	logic signed [18:0] t_prod;
	logic signed [9:0]  t_next, t_wrap;
	logic               enc;

	assign enc = !cfg.direction;
	assign x_s = $signed({2'b00, sym_q}) - $signed({2'b00, dac_pkg::LETTER_BASE});

	always_comb begin
		case (cmd)
			dac_pkg::CMD_MOD1: mul_op = enc ? cfg.inner_mult : invc_q;
			dac_pkg::CMD_MOD2: mul_op = enc ? cfg.outer_mult : inva_q;
			default:           mul_op = 8'd0;
		endcase
	end

	assign prod   = mul_op * acc_q;
	assign prod_s = $signed({2'b00, prod});

	always_comb begin
		v         = 18'sd0;
		divisor   = cfg.modulus;
		dest      = dac_pkg::DST_ACC;
		start_div = 1'b1;
		case (cmd)
			dac_pkg::CMD_MOD0: begin
				if (enc)
					v = 18'(x_s) + 18'(chain_q);
				else
					v = 18'($signed(sym_q)) - $signed({10'd0, cfg.outer_add});
			end
			dac_pkg::CMD_MOD1: begin
				if (enc)
					v = prod_s + $signed({10'd0, cfg.inner_add});
				else
					v = prod_s - $signed({10'd0, cfg.inner_add});
			end
			dac_pkg::CMD_MOD2: begin
				if (enc)
					v = prod_s + $signed({10'd0, cfg.outer_add});
				else
					v = prod_s - 18'(chain_q);
			end
			dac_pkg::CMD_EU_INIT_A: begin
				v    = $signed({10'd0, cfg.inner_mult});
				dest = dac_pkg::DST_EU_INIT;
			end
			dac_pkg::CMD_EU_INIT_C: begin
				v    = $signed({10'd0, cfg.outer_mult});
				dest = dac_pkg::DST_EU_INIT;
			end
			dac_pkg::CMD_EU_STEP: begin
				v       = $signed({10'd0, r0_q});
				divisor = r1_q;
				dest    = dac_pkg::DST_EU_STEP;
			end
			default: start_div = 1'b0;
		endcase
	end

	assign mag = v[17] ? 17'(-v) : v[16:0];

	assign trial   = {rem_q, mag_q[16]};
	assign ge      = trial >= {1'b0, div_q};
	assign rem_fix = (neg_q && rem_q != 8'd0) ? div_q - rem_q : rem_q;

	assign t_prod  = $signed({1'b0, mag_q[7:0]}) * t1_q;
	assign t_next  = t0_q - 10'(t_prod);
	assign t_wrap  = t0_q + $signed({2'b00, cfg.modulus});
	assign inv_res = (r0_q != 8'd1) ? 8'd0 : (t0_q[9] ? t_wrap[7:0] : t0_q[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			inv_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			chain_q     <= '0;
		end else begin
			if (start_div) begin
				busy_q <= 1'b1;
				cnt_q  <= dac_pkg::CNT_W'(dac_pkg::DIV_STEPS);
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
			end

			if (cfg_wr)
				inv_valid_q <= 1'b0;
			else if (cmd == dac_pkg::CMD_SAVE_C)
				inv_valid_q <= 1'b1;

			if (cmd == dac_pkg::CMD_LOAD && start_of_message)
				chain_q <= '0;
			else if (cmd == dac_pkg::CMD_WRITE_OK)
				chain_q <= enc ? x_s : $signed({2'b00, acc_q});

			if (cmd == dac_pkg::CMD_WRITE_OK || cmd == dac_pkg::CMD_WRITE_BAD)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == dac_pkg::CMD_LOAD)
			sym_q <= symbol;
		if (cmd == dac_pkg::CMD_SAVE_A)
			inva_q <= inv_res;
		if (cmd == dac_pkg::CMD_SAVE_C)
			invc_q <= inv_res;
		if (cmd == dac_pkg::CMD_EU_INIT_A || cmd == dac_pkg::CMD_EU_INIT_C) begin
			r0_q <= cfg.modulus;
			t0_q <= 10'sd0;
			t1_q <= 10'sd1;
		end
		if (start_div) begin
			mag_q  <= mag;
			rem_q  <= 8'd0;
			div_q  <= divisor;
			neg_q  <= v[17];
			dest_q <= dest;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? 8'(trial - {1'b0, div_q}) : trial[7:0];
			mag_q <= {mag_q[15:0], ge};
		end else if (busy_q) begin
			case (dest_q)
				dac_pkg::DST_ACC:     acc_q <= rem_fix;
				dac_pkg::DST_EU_INIT: r1_q  <= rem_q;
				dac_pkg::DST_EU_STEP: begin
					r0_q <= r1_q;
					r1_q <= rem_q;
					t0_q <= t1_q;
					t1_q <= t_next;
				end
				default: ;
			endcase
		end
		if (cmd == dac_pkg::CMD_WRITE_OK) begin
			out_symbol_q  <= enc ? acc_q : acc_q + dac_pkg::LETTER_BASE;
			key_invalid_q <= 1'b0;
		end else if (cmd == dac_pkg::CMD_WRITE_BAD) begin
			out_symbol_q  <= 8'd0;
			key_invalid_q <= 1'b1;
		end
	end

	assign stat.busy      = busy_q;
	assign stat.r1_zero   = (r1_q == 8'd0);
	assign stat.key_zero  = (cfg.modulus == 8'd0) || (cfg.inner_mult == 8'd0) ||
	                        (cfg.inner_add == 8'd0) || (cfg.outer_mult == 8'd0) ||
	                        (cfg.outer_add == 8'd0);
	assign stat.inv_valid = inv_valid_q;
	assign stat.inv_ok    = (inva_q != 8'd0) && (invc_q != 8'd0);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_symbol  = out_symbol_q;
	assign key_invalid = key_invalid_q;
endmodule

// ----- rtl/core/dac_chk.sv -----
module dac_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_symbol,
	input logic       key_invalid
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word taken while previous word still in work");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_invalid |-> out_symbol == 8'd0)
		else $error("invalid key result carries a symbol");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
endmodule

bind chained_double_affine_cipher_unit dac_chk u_dac_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_symbol (result.out_symbol),
	.key_invalid(result.key_invalid)
);
